FILE: src/pdf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Pareto dominance filter.
// No dependencies; every other file imports this package.
package pdf_pkg;

	localparam int MEAS_W        = 48;
	localparam int CMD_W         = 2;
	localparam int COUNT_W       = 6;
	localparam int DEPTH_DEFAULT = 32;
	// 10000 = 5^4 * 16: four multiply-by-five steps, then a shift by four
	localparam int SEED_STEPS    = 4;
	localparam int SEED_SHIFT    = 4;

	typedef logic [MEAS_W-1:0] meas_t;

	localparam meas_t ONE_Q16    = 48'h0000_0001_0000;
	// largest value whose product with 10000 still fits in 48 bits
	localparam meas_t SEED_LIMIT = 48'd28147497671;
	localparam meas_t MEAS_MAX   = '1;

	typedef struct packed {
		meas_t f;
		meas_t c;
		meas_t o;
	} triplet_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_ADD   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_SEED_WR,
		ST_WALK,
		ST_DRAIN,
		ST_PLACE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic seed_step;
		logic seed_wr;
		logic rd_en;
		logic place;
		logic out_load;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t op;
		logic out_busy;
	} dp_sts_t;

	function automatic meas_t max_meas(input meas_t a, input meas_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

FILE: src/pdf_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the Pareto dominance filter.
// Depends on pdf_pkg.
interface pdf_in_if import pdf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	meas_t              measure_f;
	meas_t              measure_c;
	meas_t              measure_o;

	modport source (output valid, output cmd, output measure_f, output measure_c,
		output measure_o, input ready);
	modport sink (input valid, input cmd, input measure_f, input measure_c,
		input measure_o, output ready);
endinterface

interface pdf_out_if import pdf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               rejected;
	logic               overflow;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, output rejected, output overflow, output entry_count,
		input ready);
	modport sink (input valid, input rejected, input overflow, input entry_count,
		output ready);
endinterface

FILE: src/pdf_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the Pareto dominance filter: seed steps, table walk,
// placement and response hand-off. Depends on pdf_pkg.
module pdf_ctrl import pdf_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] in_cmd,
	input  dp_sts_t          sts,
	output dp_ctl_t          ctl,
	output logic [IDX_W-1:0] rd_addr
);

	localparam int STEP_W = (SEED_STEPS > 1) ? $clog2(SEED_STEPS) : 1;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEED_STEPS - 1);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q;
	logic [STEP_W-1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WALK) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (state_q == ST_SEED) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd_t'(in_cmd))
						CMD_START: state_d = ST_SEED;
						CMD_QUERY: state_d = ST_WALK;
						CMD_ADD:   state_d = ST_WALK;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SEED: begin
				if (step_q == STEP_LAST) state_d = ST_SEED_WR;
			end
			ST_SEED_WR: state_d = ST_DONE;
			ST_WALK: begin
				if (idx_q == IDX_LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = (sts.op == CMD_ADD) ? ST_PLACE : ST_DONE;
			ST_PLACE: state_d = ST_DONE;
			ST_DONE: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		ctl.load      = (state_q == ST_IDLE) && in_valid;
		ctl.seed_step = (state_q == ST_SEED);
		ctl.seed_wr   = (state_q == ST_SEED_WR);
		ctl.rd_en     = (state_q == ST_WALK);
		ctl.place     = (state_q == ST_PLACE);
		ctl.out_load  = (state_q == ST_DONE) && !sts.out_busy;
		rd_addr       = idx_q;
	end

endmodule

FILE: src/pdf_dp.sv
`timescale 1ns / 1ps
// Datapath of the Pareto dominance filter: entry memory, valid bits, bounds,
// seed scaling, dominance compares and the response register. Depends on pdf_pkg, pdf_if.
module pdf_dp import pdf_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CMD_W-1:0] in_cmd,
	input  meas_t            in_f,
	input  meas_t            in_c,
	input  meas_t            in_o,
	input  dp_ctl_t          ctl,
	input  logic [IDX_W-1:0] rd_addr,
	output dp_sts_t          sts,
	pdf_out_if.source        rsp
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	cmd_t               op_q;
	triplet_t           new_q;
	meas_t              acc_q [3];
	logic [2:0]         sat_q;
	triplet_t           bound_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	triplet_t           entry_mem_q [TABLE_DEPTH];

	triplet_t           rdata_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               vld_s1;
	logic               scan_s1;

	logic               hit_q;
	logic               any_keep_q;
	triplet_t           kmax_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               ovf_q;

	logic               out_valid_q;
	logic               rejected_q;
	logic               overflow_q;
	logic [COUNT_W-1:0] entry_count_q;

	meas_t              in_meas [3];
	meas_t              seed_val [3];
	triplet_t           seed_trip;
	logic               dominates;
	logic               beaten;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	triplet_t           mem_wdata;

	assign in_meas[0] = in_f;
	assign in_meas[1] = in_c;
	assign in_meas[2] = in_o;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			seed_val[k] = sat_q[k] ? MEAS_MAX
				: {acc_q[k][MEAS_W-SEED_SHIFT-1:0], {SEED_SHIFT{1'b0}}};
		end
		seed_trip = '{f: seed_val[0], c: seed_val[1], o: seed_val[2]};
	end

	assign dominates = (new_q.f >= rdata_s1.f) && (new_q.c >= rdata_s1.c)
		&& (new_q.o >= rdata_s1.o);
	assign beaten    = (new_q.f < rdata_s1.f) && (new_q.c < rdata_s1.c)
		&& (new_q.o < rdata_s1.o);

	assign mem_we    = ctl.seed_wr || (ctl.place && free_found_q);
	assign mem_waddr = ctl.seed_wr ? '0 : free_idx_q;
	assign mem_wdata = ctl.seed_wr ? seed_trip : new_q;

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) entry_mem_q[mem_waddr] <= mem_wdata;
		if (ctl.rd_en) rdata_s1 <= entry_mem_q[rd_addr];
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= cmd_t'(in_cmd);
			new_q <= '{f: in_f, c: in_c, o: in_o};
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= max_meas(in_meas[k], ONE_Q16);
				sat_q[k] <= in_meas[k] > SEED_LIMIT;
			end
		end else if (ctl.seed_step) begin
			// multiply by five
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= {acc_q[k][MEAS_W-3:0], 2'b00} + acc_q[k];
			end
		end
		if (ctl.rd_en) begin
			idx_s1 <= rd_addr;
			vld_s1 <= valid_q[rd_addr];
		end
		if (ctl.load) begin
			kmax_q <= '0;
		end else if (scan_s1 && op_q == CMD_ADD && vld_s1 && !beaten) begin
			kmax_q.f <= any_keep_q ? max_meas(kmax_q.f, rdata_s1.f) : rdata_s1.f;
			kmax_q.c <= any_keep_q ? max_meas(kmax_q.c, rdata_s1.c) : rdata_s1.c;
			kmax_q.o <= any_keep_q ? max_meas(kmax_q.o, rdata_s1.o) : rdata_s1.o;
		end
		if (ctl.load) begin
			free_idx_q <= '0;
		end else if (scan_s1 && !free_found_q && (!vld_s1 || beaten)) begin
			free_idx_q <= idx_s1;
		end
		if (ctl.out_load) begin
			rejected_q    <= (op_q == CMD_QUERY) && hit_q;
			overflow_q    <= (op_q == CMD_ADD) && ovf_q;
			entry_count_q <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q      <= '0;
			valid_q      <= '0;
			count_q      <= '0;
			scan_s1      <= 1'b0;
			hit_q        <= 1'b0;
			any_keep_q   <= 1'b0;
			free_found_q <= 1'b0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			scan_s1 <= ctl.rd_en;
			if (ctl.load) begin
				// bound check is taken against the bounds as they stand now
				hit_q        <= (in_f >= bound_q.f) || (in_c >= bound_q.c)
					|| (in_o >= bound_q.o);
				any_keep_q   <= 1'b0;
				free_found_q <= 1'b0;
				ovf_q        <= 1'b0;
			end
			if (ctl.seed_wr) begin
				bound_q <= seed_trip;
				valid_q <= TABLE_DEPTH'(1);
				count_q <= CNT_W'(1);
			end
			if (scan_s1) begin
				if (op_q == CMD_QUERY && vld_s1 && dominates) hit_q <= 1'b1;
				if (op_q == CMD_ADD) begin
					if (vld_s1 && beaten) begin
						valid_q[idx_s1] <= 1'b0;
						count_q         <= count_q - 1'b1;
					end
					if (vld_s1 && !beaten) any_keep_q <= 1'b1;
					if (!vld_s1 || beaten) free_found_q <= 1'b1;
				end
			end
			if (ctl.place) begin
				if (free_found_q) begin
					valid_q[free_idx_q] <= 1'b1;
					count_q             <= count_q + 1'b1;
					bound_q.f <= any_keep_q ? max_meas(kmax_q.f, new_q.f) : new_q.f;
					bound_q.c <= any_keep_q ? max_meas(kmax_q.c, new_q.c) : new_q.c;
					bound_q.o <= any_keep_q ? max_meas(kmax_q.o, new_q.o) : new_q.o;
				end else begin
					// table full: drop the triplet, bounds from what is held
					bound_q <= kmax_q;
					ovf_q   <= 1'b1;
				end
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op       = op_q;
	assign sts.out_busy = out_valid_q && !rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.rejected    = rejected_q;
	assign rsp.overflow    = overflow_q;
	assign rsp.entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !(out_valid_q && !rsp.ready))
		else $error("response loaded over a pending response");

	a_seed_one: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.seed_wr |=> (count_q == CNT_W'(1)) && valid_q[0])
		else $error("seed did not leave exactly one entry");

	a_place_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.place && free_found_q) |=> count_q == $past(count_q) + 1'b1)
		else $error("placement did not raise the entry count");

endmodule

FILE: src/pareto_dominance_filter.sv
`timescale 1ns / 1ps
// Pareto dominance filter top level. Depends on pdf_pkg, pdf_if, pdf_ctrl, pdf_dp.
// One request at a time; the next is taken in the cycle after the response is loaded.
// The table walk reads the entry memory one entry per cycle.
// Reset empties the table and clears the bounds at once; no clearing pass is run.
module pareto_dominance_filter import pdf_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	pdf_in_if.sink     req,
	pdf_out_if.source  rsp
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	dp_ctl_t          ctl;
	dp_sts_t          sts;
	logic [IDX_W-1:0] rd_addr;

	pdf_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_cmd   (req.cmd),
		.sts      (sts),
		.ctl      (ctl),
		.rd_addr  (rd_addr)
	);

	pdf_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_cmd  (req.cmd),
		.in_f    (req.measure_f),
		.in_c    (req.measure_c),
		.in_o    (req.measure_o),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of pareto_dominance_filter: directed requests, then random
// start/add/query/nop sequences, checked against fixed replies or a cycle-free
// model of the filter table. Depends on pdf_pkg, pdf_if and the filter RTL.
module tb_top;
	import pdf_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int NUM_OPENING = 25;
	localparam int PHASE_QUOTA = 225;
	localparam int MAX_SHOWN   = 10;

	typedef struct packed {
		logic               rejected;
		logic               overflow;
		logic [COUNT_W-1:0] entry_count;
	} filter_reply_t;

	typedef struct packed {
		cmd_t          op;
		meas_t         f;
		meas_t         c;
		meas_t         o;
		bit            fixed;
		filter_reply_t reply;
	} opening_row_t;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	pdf_in_if  req_ch ();
	pdf_out_if rsp_ch ();

	pareto_dominance_filter #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model of the filter table
	meas_t held_f [DEPTH];
	meas_t held_c [DEPTH];
	meas_t held_o [DEPTH];
	bit    held_live [DEPTH];
	meas_t ceil_f, ceil_c, ceil_o;

	filter_reply_t awaited_replies [$];
	idle_mode_t    idle_mode = IDLE_NONE;
	int            requests_taken = 0;
	int            replies_seen = 0;
	int            mismatches = 0;

	opening_row_t opening_rows [NUM_OPENING] = '{
		'{CMD_QUERY, 48'd0, 48'd0, 48'd0, 1'b1, '{1'b1, 1'b0, 6'd0}},
		'{CMD_QUERY, MEAS_MAX, MEAS_MAX, MEAS_MAX, 1'b1, '{1'b1, 1'b0, 6'd0}},
		'{CMD_NOP, 48'd0, 48'd0, 48'd0, 1'b1, '{1'b0, 1'b0, 6'd0}},
		'{CMD_ADD, 48'd100, 48'd200, 48'd300, 1'b1, '{1'b0, 1'b0, 6'd1}},
		'{CMD_QUERY, 48'd100, 48'd200, 48'd300, 1'b1, '{1'b1, 1'b0, 6'd1}},
		'{CMD_QUERY, 48'd99, 48'd199, 48'd299, 1'b1, '{1'b0, 1'b0, 6'd1}},
		'{CMD_START, 48'd0, 48'd0, 48'd0, 1'b1, '{1'b0, 1'b0, 6'd1}},
		'{CMD_QUERY, 48'd655359999, 48'd655359999, 48'd655359999, 1'b1,
			'{1'b0, 1'b0, 6'd1}},
		'{CMD_QUERY, 48'd655360000, 48'd0, 48'd0, 1'b1, '{1'b1, 1'b0, 6'd1}},
		'{CMD_START, MEAS_MAX, MEAS_MAX, MEAS_MAX, 1'b1, '{1'b0, 1'b0, 6'd1}},
		'{CMD_QUERY, MEAS_MAX - 48'd1, MEAS_MAX - 48'd1, MEAS_MAX - 48'd1, 1'b1,
			'{1'b0, 1'b0, 6'd1}},
		'{CMD_QUERY, 48'd0, 48'd0, MEAS_MAX, 1'b1, '{1'b1, 1'b0, 6'd1}},
		'{CMD_START, SEED_LIMIT, SEED_LIMIT + 48'd1, 48'hFFFF, 1'b1, '{1'b0, 1'b0, 6'd1}},
		'{CMD_QUERY, 48'd281474976709999, MEAS_MAX - 48'd1, 48'd655359999, 1'b0, '0},
		'{CMD_QUERY, 48'd281474976710000, 48'd0, 48'd0, 1'b0, '0},
		'{CMD_ADD, 48'd1000, 48'd2000, 48'd3000, 1'b0, '0},
		'{CMD_ADD, 48'd2000, 48'd1000, 48'd3000, 1'b0, '0},
		'{CMD_ADD, 48'd500, 48'd500, 48'd500, 1'b0, '0},
		'{CMD_ADD, 48'd500, 48'd500, 48'd500, 1'b0, '0},
		'{CMD_QUERY, 48'd500, 48'd500, 48'd500, 1'b0, '0},
		'{CMD_QUERY, 48'd499, 48'd499, 48'd499, 1'b0, '0},
		'{CMD_ADD, 48'd0, 48'd0, 48'd0, 1'b0, '0},
		'{CMD_QUERY, 48'd0, 48'd0, 48'd0, 1'b0, '0},
		'{CMD_NOP, MEAS_MAX, MEAS_MAX, MEAS_MAX, 1'b0, '0},
		'{CMD_START, 48'h10000, 48'h10001, 48'h20000, 1'b0, '0}
	};

	// 10000 * max(1.0, v), saturating at the measure width
	function automatic meas_t seed_scaled(input meas_t v);
		logic [63:0] m;
		logic [63:0] p;
		m = (v < ONE_Q16) ? {16'd0, ONE_Q16} : {16'd0, v};
		p = m * 64'd10000;
		return (p > {16'd0, MEAS_MAX}) ? MEAS_MAX : p[MEAS_W-1:0];
	endfunction

	function automatic filter_reply_t filter_apply(input logic [1:0] op,
			input meas_t f, input meas_t c, input meas_t o);
		filter_reply_t r;
		bit placed;
		bit any;
		int live;
		r = '0;
		placed = 1'b0;
		any = 1'b0;
		live = 0;
		case (op)
			CMD_START: begin
				held_live = '{default: 1'b0};
				ceil_f = seed_scaled(f);
				ceil_c = seed_scaled(c);
				ceil_o = seed_scaled(o);
				held_f[0] = ceil_f;
				held_c[0] = ceil_c;
				held_o[0] = ceil_o;
				held_live[0] = 1'b1;
			end
			CMD_QUERY: begin
				r.rejected = (f >= ceil_f) || (c >= ceil_c) || (o >= ceil_o);
				for (int i = 0; i < DEPTH; i++)
					if (held_live[i] && f >= held_f[i] && c >= held_c[i] && o >= held_o[i])
						r.rejected = 1'b1;
			end
			CMD_ADD: begin
				// drop entries beaten strictly in every measure, then take the lowest free slot
				for (int i = 0; i < DEPTH; i++)
					if (held_live[i] && f < held_f[i] && c < held_c[i] && o < held_o[i])
						held_live[i] = 1'b0;
				for (int i = 0; i < DEPTH; i++)
					if (!placed && !held_live[i]) begin
						held_f[i] = f;
						held_c[i] = c;
						held_o[i] = o;
						held_live[i] = 1'b1;
						placed = 1'b1;
					end
				r.overflow = !placed;
				for (int i = 0; i < DEPTH; i++)
					if (held_live[i]) begin
						if (!any || held_f[i] > ceil_f) ceil_f = held_f[i];
						if (!any || held_c[i] > ceil_c) ceil_c = held_c[i];
						if (!any || held_o[i] > ceil_o) ceil_o = held_o[i];
						any = 1'b1;
					end
			end
			default: ;
		endcase
		for (int i = 0; i < DEPTH; i++)
			live += held_live[i];
		r.entry_count = live[COUNT_W-1:0];
		return r;
	endfunction

	function automatic meas_t rnd_meas();
		return meas_t'({$urandom(), $urandom()});
	endfunction

	function automatic meas_t below(input meas_t s);
		return (s == '0) ? '0 : rnd_meas() % s;
	endfunction

	function automatic meas_t nudge();
		return meas_t'($urandom_range(0, 6)) - meas_t'(3);
	endfunction

	// spread points lie along an anti-correlated front, so few of them beat each other
	function automatic triplet_t make_point(input bit spread, input meas_t sf,
			input meas_t sc, input meas_t so);
		triplet_t t;
		meas_t u;
		if (spread) begin
			u = meas_t'($urandom_range(0, 1023));
			t.f = (sf >> 10) * u + below(sf >> 10);
			t.c = (sc >> 10) * (meas_t'(1023) - u) + below(sc >> 10);
			t.o = below(so);
		end else begin
			t.f = below(sf);
			t.c = below(sc);
			t.o = below(so);
		end
		return t;
	endfunction

	function automatic bit sender_holds();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(0, 99) < 87;
			IDLE_BOTH: return $urandom_range(0, 99) < 26;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(0, 99) < 87;
			IDLE_BOTH: return $urandom_range(0, 99) < 26;
			default:   return 1'b0;
		endcase
	endfunction

	task automatic note_fault(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	// entered and left at a falling edge; valid stays high for the caller to reuse
	task automatic issue_request(input logic [1:0] op, input meas_t f, input meas_t c,
			input meas_t o, input bit fixed = 1'b0, input filter_reply_t fixed_reply = '0);
		filter_reply_t predicted;
		while (sender_holds()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.measure_f <= f;
		req_ch.measure_c <= c;
		req_ch.measure_o <= o;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = filter_apply(op, f, c, o);
		awaited_replies.push_back(fixed ? fixed_reply : predicted);
		requests_taken++;
		@(negedge clk);
	endtask

	task automatic await_replies();
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_sequence(input int ops);
		meas_t sf, sc, so;
		triplet_t t;
		bit spread;
		int pick;
		int k;
		int live_idx [$];
		case ($urandom_range(0, 3))
			0: issue_request(CMD_START, below(48'h20000), below(48'h20000), below(48'h20000));
			1: issue_request(CMD_START, rnd_meas(), rnd_meas(), rnd_meas());
			2: issue_request(CMD_START, SEED_LIMIT + nudge(), SEED_LIMIT + nudge(),
				SEED_LIMIT + nudge());
			default: issue_request(CMD_START, below(ONE_Q16), below(ONE_Q16), below(ONE_Q16));
		endcase
		sf = ceil_f;
		sc = ceil_c;
		so = ceil_o;
		spread = $urandom_range(0, 1);
		repeat (ops) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				t = make_point(spread, sf, sc, so);
				// now and then a much smaller triplet, to sweep out part of the table
				if ($urandom_range(0, 19) == 0)
					t = '{t.f >> 3, t.c >> 3, t.o >> 3};
				issue_request(CMD_ADD, t.f, t.c, t.o);
			end else if (pick < 88) begin
				live_idx.delete();
				for (int i = 0; i < DEPTH; i++)
					if (held_live[i])
						live_idx.push_back(i);
				if (live_idx.size() > 0 && $urandom_range(0, 9) < 6) begin
					k = live_idx[$urandom_range(0, live_idx.size() - 1)];
					t = '{held_f[k] + nudge(), held_c[k] + nudge(), held_o[k] + nudge()};
				end else begin
					t = make_point(spread, sf, sc, so);
				end
				issue_request(CMD_QUERY, t.f, t.c, t.o);
			end else if (pick < 93) begin
				issue_request(CMD_NOP, rnd_meas(), rnd_meas(), rnd_meas());
			end else begin
				issue_request(2'($urandom_range(0, 3)), rnd_meas(), rnd_meas(), rnd_meas());
			end
		end
	endtask

	always @(negedge clk) begin
		rsp_ch.ready <= !receiver_stalls();
	end

	always @(posedge clk) begin : check_replies
		filter_reply_t want;
		filter_reply_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.rejected, rsp_ch.overflow, rsp_ch.entry_count};
			if (awaited_replies.size() == 0) begin
				note_fault($sformatf("reply %0d arrived with no request outstanding",
					replies_seen));
			end else begin
				want = awaited_replies.pop_front();
				if (got.rejected !== want.rejected)
					note_fault($sformatf("reply %0d rejected: expected %0b, got %0b",
						replies_seen, want.rejected, got.rejected));
				if (got.overflow !== want.overflow)
					note_fault($sformatf("reply %0d overflow: expected %0b, got %0b",
						replies_seen, want.overflow, got.overflow));
				if (got.entry_count !== want.entry_count)
					note_fault($sformatf("reply %0d entry_count: expected %0d, got %0d",
						replies_seen, want.entry_count, got.entry_count));
			end
			replies_seen++;
		end
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d replies outstanding", awaited_replies.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		idle_mode_t phase_modes [4];
		int target;
		phase_modes = '{IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};
		held_f = '{default: '0};
		held_c = '{default: '0};
		held_o = '{default: '0};
		held_live = '{default: 1'b0};
		ceil_f = '0;
		ceil_c = '0;
		ceil_o = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_NOP;
		req_ch.measure_f = '0;
		req_ch.measure_c = '0;
		req_ch.measure_o = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_rows[i])
			issue_request(opening_rows[i].op, opening_rows[i].f, opening_rows[i].c,
				opening_rows[i].o, opening_rows[i].fixed, opening_rows[i].reply);

		foreach (phase_modes[p]) begin
			// hold the sender until the block has answered everything
			await_replies();
			idle_mode = phase_modes[p];
			target = requests_taken + PHASE_QUOTA;
			if (p == 0) begin
				// fill the table along a front, overflow it, then knock out one entry
				issue_request(CMD_START, '0, '0, '0);
				for (int k = 0; k < DEPTH + 3; k++)
					issue_request(CMD_ADD, meas_t'(1000 + 10 * k), meas_t'(100000 - 10 * k),
						meas_t'(5000));
				issue_request(CMD_QUERY, meas_t'(1055), meas_t'(99955), meas_t'(5000));
				issue_request(CMD_ADD, meas_t'(1049), meas_t'(99949), meas_t'(4999));
				issue_request(CMD_QUERY, meas_t'(1049), meas_t'(99949), meas_t'(4999));
				issue_request(CMD_ADD, '0, '0, '0);
			end
			while (requests_taken < target)
				run_sequence($urandom_range(12, 60));
		end

		await_replies();
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
